### sv/rand_error_pair_counter_macros.svh
// Assertion macros shared by the pair counter RTL.
`ifndef RAND_ERROR_PAIR_COUNTER_MACROS_SVH
`define RAND_ERROR_PAIR_COUNTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define REPC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define REPC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/repc_pkg.sv
// Package with sizes, types and helper functions of the pair counter.
package repc_pkg;

    localparam int SEG_LABELS   = 256;
    localparam int TRUTH_LABELS = 256;
    localparam int MAX_VOXELS   = 16777216;

    localparam int LABEL_W     = 8;
    localparam int SEG_AW      = $clog2(SEG_LABELS);
    localparam int TRUTH_AW    = $clog2(TRUTH_LABELS);
    localparam int JOINT_AW    = SEG_AW + TRUTH_AW;
    localparam int JOINT_DEPTH = SEG_LABELS * TRUTH_LABELS;
    localparam int COUNT_W     = $clog2(MAX_VOXELS + 1);
    localparam int ACC_W       = 48;
    localparam int PROD_W      = 2 * COUNT_W;
    localparam int PAIR_W      = 47;
    localparam int NZ_W        = 25;

    localparam int IN_TDATA_W  = 2 * LABEL_W;
    localparam int OUT_FIELD_W = 4 * PAIR_W + NZ_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [PAIR_W-1:0] PAIR_MAX = '1;
    localparam logic [NZ_W-1:0]   NZ_MAX   = '1;

    typedef struct packed {
        logic [ACC_W-1:0]   both;
        logic [ACC_W-1:0]   seg;
        logic [ACC_W-1:0]   truth;
        logic [COUNT_W-1:0] nonzero;
        logic               ovf;
    } repc_snap_t;

    function automatic logic [SEG_AW-1:0] sat_seg(input logic [LABEL_W-1:0] lbl);
        if (32'(lbl) >= SEG_LABELS) begin
            return SEG_AW'(SEG_LABELS - 1);
        end
        return SEG_AW'(lbl);
    endfunction

    function automatic logic [TRUTH_AW-1:0] sat_truth(input logic [LABEL_W-1:0] lbl);
        if (32'(lbl) >= TRUTH_LABELS) begin
            return TRUTH_AW'(TRUTH_LABELS - 1);
        end
        return TRUTH_AW'(lbl);
    endfunction

    function automatic logic [PAIR_W-1:0] sat_pair(input logic [63:0] v);
        if (v > 64'(PAIR_MAX)) begin
            return PAIR_MAX;
        end
        return v[PAIR_W-1:0];
    endfunction

    function automatic logic [NZ_W-1:0] sat_nz(input logic [63:0] v);
        if (v > 64'(NZ_MAX)) begin
            return NZ_MAX;
        end
        return v[NZ_W-1:0];
    endfunction

endpackage

### sv/repc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module repc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/repc_result.sv
// Result path: pair differences, total pair product, saturation and output register.
module repc_result (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                snap_valid,
    input  repc_pkg::repc_snap_t                snap,
    output logic                                busy,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [repc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tuser
);
    import repc_pkg::*;

    repc_snap_t         r1_reg;
    logic               r1_valid_reg, r1_valid_next;
    logic               r2_valid_reg, r2_valid_next;
    logic [ACC_W-1:0]   r2_both_reg, r2_merge_reg, r2_split_reg;
    logic [ACC_W-1:0]   r2_merge_next, r2_split_next;
    logic [PROD_W-1:0]  r2_prod_reg, r2_prod_next;
    logic [COUNT_W-1:0] r2_nz_reg;
    logic               r2_ovf_reg;
    logic [COUNT_W-1:0] nz_less;
    logic               out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic               out_user_reg;
    logic               out_ready, r2_move, r1_move;

    assign out_ready = !out_valid_reg || m_tready;
    assign r2_move   = r2_valid_reg && out_ready;
    assign r1_move   = r1_valid_reg && (!r2_valid_reg || r2_move);
    assign busy      = r1_valid_reg || r2_valid_reg;

    always_comb begin
        r1_valid_next  = snap_valid || (r1_valid_reg && !r1_move);
        r2_valid_next  = r1_move || (r2_valid_reg && !r2_move);
        out_valid_next = r2_move || (out_valid_reg && !m_tready);

        nz_less       = r1_reg.nonzero - COUNT_W'(r1_reg.nonzero != '0);
        r2_merge_next = r1_reg.seg - r1_reg.both;
        r2_split_next = r1_reg.truth - r1_reg.both;
        r2_prod_next  = PROD_W'(r1_reg.nonzero) * PROD_W'(nz_less);

        out_data_next = {OUT_PAD_W'(0),
                         sat_nz(64'(r2_nz_reg)),
                         sat_pair(64'(r2_prod_reg[PROD_W-1:1])),
                         sat_pair(64'(r2_split_reg)),
                         sat_pair(64'(r2_merge_reg)),
                         sat_pair(64'(r2_both_reg))};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg  <= 1'b0;
            r2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            r1_valid_reg  <= r1_valid_next;
            r2_valid_reg  <= r2_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (snap_valid) begin
            r1_reg <= snap;
        end
        if (r1_move) begin
            r2_both_reg  <= r1_reg.both;
            r2_merge_reg <= r2_merge_next;
            r2_split_reg <= r2_split_next;
            r2_prod_reg  <= r2_prod_next;
            r2_nz_reg    <= r1_reg.nonzero;
            r2_ovf_reg   <= r1_reg.ovf;
        end
        if (r2_move) begin
            out_data_reg <= out_data_next;
            out_user_reg <= r2_ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### sv/rand_error_pair_counter.sv
// Top level of the Rand-index pair counter over a stream of labelled voxels.
//
//   Channel  Direction  Contents
//   s_       in         voxel labels, tlast marks the last voxel of a volume
//   m_       out        pair counts of one volume, tuser is the overflow flag
//   cfg_     in         mask_truth_zero register write
//
// One voxel transaction is accepted every cycle while the input is not stalled;
// the count memories are read at acceptance and written back in the cycle after,
// with forwarding between neighboring voxels. A volume result passes the result
// path registers r1 and r2 and then the output register after its last voxel.
// After reset and after every last voxel, a clearing pass writes all 65536 joint
// count entries, one per cycle, and no voxel is accepted until it ends.
// A last voxel also holds the input while it is counted, and a result waiting in
// the output register does not stall the input.
module rand_error_pair_counter (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: seg_label, truth_label.
    input  logic [repc_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: true_pairs, merge_pairs, split_pairs, total_pairs,
    // nonzero_voxels, zero padding.
    output logic [repc_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Fields from bit 0: overflowed.
    output logic                                m_tuser
);
    import repc_pkg::*;

`include "rand_error_pair_counter_macros.svh"

    logic                  mask_reg;
    logic                  clear_busy_reg, clear_busy_next;
    logic [JOINT_AW-1:0]   clear_addr_reg, clear_addr_next;

    logic                  st1_valid_reg, st1_last_reg;
    logic [SEG_AW-1:0]     st1_seg_reg;
    logic [TRUTH_AW-1:0]   st1_truth_reg;

    logic                  fwd_valid_reg;
    logic [SEG_AW-1:0]     fwd_seg_reg;
    logic [TRUTH_AW-1:0]   fwd_truth_reg;
    logic [COUNT_W-1:0]    fwd_joint_reg, fwd_segcnt_reg, fwd_truthcnt_reg;

    logic [ACC_W-1:0]      both_reg, both_next, segp_reg, segp_next, truthp_reg, truthp_next;
    logic [COUNT_W-1:0]    nz_reg, nz_next, vol_reg, vol_next;
    logic                  ovf_reg, ovf_next;

    logic [SEG_AW-1:0]     in_seg;
    logic [TRUTH_AW-1:0]   in_truth;
    logic                  accept;

    logic [COUNT_W-1:0]    joint_rdata, seg_rdata, truth_rdata;
    logic [COUNT_W-1:0]    j_old, s_old, t_old, j_new, s_new, t_new;
    logic                  vol_full, counted, upd;
    logic                  mem_we;
    logic [JOINT_AW-1:0]   joint_waddr;
    logic [SEG_AW-1:0]     seg_waddr;
    logic [TRUTH_AW-1:0]   truth_waddr;
    logic [COUNT_W-1:0]    joint_wdata, seg_wdata, truth_wdata;

    logic                  snap_valid;
    repc_snap_t            snap;
    logic                  res_busy;

    assign in_seg   = sat_seg(s_tdata[LABEL_W-1:0]);
    assign in_truth = sat_truth(s_tdata[2*LABEL_W-1:LABEL_W]);
    assign s_tready = !clear_busy_reg && !(st1_valid_reg && st1_last_reg) && !res_busy;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        j_old = joint_rdata;
        s_old = seg_rdata;
        t_old = truth_rdata;
        if (fwd_valid_reg && fwd_seg_reg == st1_seg_reg && fwd_truth_reg == st1_truth_reg) begin
            j_old = fwd_joint_reg;
        end
        if (fwd_valid_reg && fwd_seg_reg == st1_seg_reg) begin
            s_old = fwd_segcnt_reg;
        end
        if (fwd_valid_reg && fwd_truth_reg == st1_truth_reg) begin
            t_old = fwd_truthcnt_reg;
        end
        j_new = j_old + COUNT_W'(1);
        s_new = s_old + COUNT_W'(1);
        t_new = t_old + COUNT_W'(1);

        vol_full = vol_reg >= COUNT_W'(MAX_VOXELS);
        counted  = st1_valid_reg && !vol_full;
        upd      = counted && !(mask_reg && st1_truth_reg == '0);

        both_next   = upd ? both_reg + ACC_W'(j_old) : both_reg;
        segp_next   = upd ? segp_reg + ACC_W'(s_old) : segp_reg;
        truthp_next = upd ? truthp_reg + ACC_W'(t_old) : truthp_reg;
        nz_next     = (counted && st1_truth_reg != '0) ? nz_reg + COUNT_W'(1) : nz_reg;
        vol_next    = counted ? vol_reg + COUNT_W'(1) : vol_reg;
        ovf_next    = ovf_reg || (st1_valid_reg && vol_full);

        snap_valid    = st1_valid_reg && st1_last_reg;
        snap.both     = both_next;
        snap.seg      = segp_next;
        snap.truth    = truthp_next;
        snap.nonzero  = nz_next;
        snap.ovf      = ovf_next;

        mem_we = upd || clear_busy_reg;
        if (clear_busy_reg) begin
            joint_waddr = clear_addr_reg;
            seg_waddr   = clear_addr_reg[SEG_AW-1:0];
            truth_waddr = clear_addr_reg[TRUTH_AW-1:0];
            joint_wdata = '0;
            seg_wdata   = '0;
            truth_wdata = '0;
        end else begin
            joint_waddr = {st1_seg_reg, st1_truth_reg};
            seg_waddr   = st1_seg_reg;
            truth_waddr = st1_truth_reg;
            joint_wdata = j_new;
            seg_wdata   = s_new;
            truth_wdata = t_new;
        end

        clear_busy_next = clear_busy_reg;
        clear_addr_next = clear_addr_reg;
        if (snap_valid) begin
            clear_busy_next = 1'b1;
            clear_addr_next = '0;
        end else if (clear_busy_reg) begin
            clear_addr_next = clear_addr_reg + JOINT_AW'(1);
            if (clear_addr_reg == JOINT_AW'(JOINT_DEPTH - 1)) begin
                clear_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg       <= 1'b0;
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            st1_valid_reg  <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            both_reg       <= '0;
            segp_reg       <= '0;
            truthp_reg     <= '0;
            nz_reg         <= '0;
            vol_reg        <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mask_reg <= cfg_wr_data;
            end
            clear_busy_reg <= clear_busy_next;
            clear_addr_reg <= clear_addr_next;
            st1_valid_reg  <= accept;
            fwd_valid_reg  <= upd;
            if (snap_valid) begin
                both_reg   <= '0;
                segp_reg   <= '0;
                truthp_reg <= '0;
                nz_reg     <= '0;
                vol_reg    <= '0;
                ovf_reg    <= 1'b0;
            end else begin
                both_reg   <= both_next;
                segp_reg   <= segp_next;
                truthp_reg <= truthp_next;
                nz_reg     <= nz_next;
                vol_reg    <= vol_next;
                ovf_reg    <= ovf_next;
            end
        end
        if (accept) begin
            st1_seg_reg   <= in_seg;
            st1_truth_reg <= in_truth;
            st1_last_reg  <= s_tlast;
        end
        fwd_seg_reg      <= st1_seg_reg;
        fwd_truth_reg    <= st1_truth_reg;
        fwd_joint_reg    <= j_new;
        fwd_segcnt_reg   <= s_new;
        fwd_truthcnt_reg <= t_new;
    end

    repc_ram #(.WIDTH(COUNT_W), .DEPTH(JOINT_DEPTH)) u_joint_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (joint_waddr),
        .wdata (joint_wdata),
        .raddr ({in_seg, in_truth}),
        .rdata (joint_rdata)
    );

    repc_ram #(.WIDTH(COUNT_W), .DEPTH(SEG_LABELS)) u_seg_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (seg_waddr),
        .wdata (seg_wdata),
        .raddr (in_seg),
        .rdata (seg_rdata)
    );

    repc_ram #(.WIDTH(COUNT_W), .DEPTH(TRUTH_LABELS)) u_truth_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (truth_waddr),
        .wdata (truth_wdata),
        .raddr (in_truth),
        .rdata (truth_rdata)
    );

    repc_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .snap_valid (snap_valid),
        .snap       (snap),
        .busy       (res_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    `REPC_ASSERT_NXT(a_clear_after_last, aclk, aresetn, snap_valid,
        clear_busy_reg && (clear_addr_reg == '0),
        "Clearing pass did not start after the last voxel.")
    `REPC_ASSERT_IMP(a_no_voxel_in_clear, aclk, aresetn, clear_busy_reg, !st1_valid_reg,
        "A voxel is being counted during the clearing pass.")
    `REPC_ASSERT_IMP(a_volume_bound, aclk, aresetn, 1'b1, vol_reg <= COUNT_W'(MAX_VOXELS),
        "Voxel counter exceeded the volume capacity.")
    `REPC_ASSERT_IMP(a_result_slot_free, aclk, aresetn, snap_valid, !res_busy,
        "A volume result entered a busy result path.")

endmodule
